### rtl/core/rcs_pkg.sv
`default_nettype none

package rcs_pkg;

   localparam int TEX_SIZE    = 64;
   localparam int TEX_COUNT   = 8;
   localparam int TEX_BITS    = $clog2(TEX_SIZE);
   localparam int OFF_W       = 2 * TEX_BITS;
   localparam int TEX_TEXELS  = TEX_SIZE * TEX_SIZE;
   localparam int STORE_DEPTH = TEX_COUNT * TEX_TEXELS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam logic [23:0] HQ_MAX = 24'hFF_FFFF;

   localparam logic [10:0] SCREEN_ROWS_RST   = 11'd600;
   localparam logic [8:0]  TILE_SIZE_RST     = 9'd64;
   localparam logic [11:0] PROJ_DIST_RST     = 12'd692;
   localparam logic [31:0] CEILING_RST       = 32'hFF44_4444;
   localparam logic [31:0] FLOOR_RST         = 32'hFF77_7777;
   localparam logic [8:0]  SHADE_RST         = 9'd179;

   typedef enum logic [2:0] {
      CSR_SCREEN_ROWS   = 3'd0,
      CSR_TILE_SIZE     = 3'd1,
      CSR_PROJ_DIST     = 3'd2,
      CSR_CEILING_COLOR = 3'd3,
      CSR_FLOOR_COLOR   = 3'd4,
      CSR_SHADE_FACTOR  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      REGION_CEILING = 2'd0,
      REGION_WALL    = 2'd1,
      REGION_FLOOR   = 2'd2
   } region_type;

   typedef struct packed {
      logic        render;
      logic [3:0]  texnum;
      logic [11:0] off;
      logic [31:0] value;
      logic [23:0] ray_len;
      logic [15:0] ang;
      logic [15:0] hit_x;
      logic [15:0] hit_y;
      logic        vert;
      logic [9:0]  row;
   } rq_type;

   typedef struct packed {
      logic                valid;
      logic                render;
      logic [3:0]          texnum;
      logic [11:0]         off;
      logic [31:0]         value;
      logic                vert;
      logic [9:0]          row;
      logic [TEX_BITS-1:0] tx;
      logic [23:0]         hq;
   } ht_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] color;
      region_type  region;
   } rs_type;

endpackage

`default_nettype wire

### rtl/core/rcs_ram.sv
`default_nettype none

module rcs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### rtl/core/rcs_height.sv
`default_nettype none

module rcs_height (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            adv,
   input  wire logic            in_valid,
   input  wire rcs_pkg::rq_type in_req,
   input  wire logic [8:0]      tile,
   input  wire logic [20:0]     tile_proj,
   output rcs_pkg::ht_type      out
);

   localparam int NS = 47;
   localparam int TB = rcs_pkg::TEX_BITS;

   typedef struct packed {
      logic        valid;
      logic        render;
      logic [3:0]  texnum;
      logic [11:0] off;
      logic [31:0] value;
      logic [23:0] ray_len;
      logic [15:0] ang;
      logic        vert;
      logic [9:0]  row;
      logic [15:0] hit;
      logic [8:0]  mrem;
      logic [13:0] u;
      logic        big;
      logic [27:0] uu;
      logic [30:0] num;
      logic [30:0] den;
      logic [30:0] crem;
      logic [16:0] cq;
      logic [23:0] perp;
      logic        hovf;
      logic [23:0] hrem;
      logic [23:0] hq;
   } hp_type;

   hp_type st_ff [NS];
   hp_type st_in [NS];

   logic [15:0] txw;

   // stages: 1-3 cosine operands, 4-20 cosine divide, 21 perp, 22-46 height divide
   always_comb begin
      logic [15:0] neg;
      logic [15:0] mag;
      logic [9:0]  mt;
      logic [31:0] ct;
      logic [24:0] ht;
      logic [16:0] cosv;
      logic [40:0] prod;
      logic        hb;
      neg  = '0;
      mag  = '0;
      mt   = '0;
      ct   = '0;
      ht   = '0;
      cosv = '0;
      prod = '0;
      hb   = 1'b0;
      st_in[0]         = '0;
      st_in[0].valid   = in_valid;
      st_in[0].render  = in_req.render;
      st_in[0].texnum  = in_req.texnum;
      st_in[0].off     = in_req.off;
      st_in[0].value   = in_req.value;
      st_in[0].ray_len = in_req.ray_len;
      st_in[0].ang     = in_req.ang;
      st_in[0].vert    = in_req.vert;
      st_in[0].row     = in_req.row;
      st_in[0].hit     = in_req.vert ? in_req.hit_y : in_req.hit_x;
      for (int i = 1; i < NS; i++) begin
         st_in[i] = st_ff[i-1];
         if (i <= 16) begin
            mt = {st_ff[i-1].mrem, st_ff[i-1].hit[16-i]};
            if (mt >= {1'b0, tile}) begin
               st_in[i].mrem = 9'(mt - {1'b0, tile});
            end else begin
               st_in[i].mrem = mt[8:0];
            end
         end
         if (i == 1) begin
            neg = 16'(~st_ff[0].ang + 16'd1);
            mag = st_ff[0].ang[15] ? neg : st_ff[0].ang;
            st_in[1].big = |mag[15:14];
            st_in[1].u   = mag[13:0];
         end
         if (i == 2) begin
            st_in[2].uu = {14'b0, st_ff[1].u} * {14'b0, st_ff[1].u};
         end
         if (i == 3) begin
            st_in[3].num  = 31'h4000_0000 - {1'b0, st_ff[2].uu, 2'b00};
            st_in[3].den  = 31'h4000_0000 + {3'b000, st_ff[2].uu};
            st_in[3].crem = {1'b0, st_in[3].num[30:1]};
            st_in[3].cq   = '0;
         end
         if (i >= 4 && i <= 20) begin
            hb = (i == 4) ? st_ff[i-1].num[0] : 1'b0;
            ct = {st_ff[i-1].crem, hb};
            if (ct >= {1'b0, st_ff[i-1].den}) begin
               st_in[i].crem = 31'(ct - {1'b0, st_ff[i-1].den});
               st_in[i].cq   = {st_ff[i-1].cq[15:0], 1'b1};
            end else begin
               st_in[i].crem = ct[30:0];
               st_in[i].cq   = {st_ff[i-1].cq[15:0], 1'b0};
            end
         end
         if (i == 21) begin
            cosv = st_ff[20].big ? 17'd0 : st_ff[20].cq;
            prod = {17'b0, st_ff[20].ray_len} * {24'b0, cosv};
            st_in[21].perp = prod[39:16];
         end
         if (i == 22) begin
            st_in[22].hovf = {11'b0, tile_proj[20:8]} >= st_ff[21].perp;
            st_in[22].hrem = {11'b0, tile_proj[20:8]};
            st_in[22].hq   = '0;
         end
         if (i >= 23) begin
            hb = 1'b0;
            if (i <= 30) begin
               hb = tile_proj[30-i];
            end
            ht = {st_ff[i-1].hrem, hb};
            if (ht >= {1'b0, st_ff[i-1].perp}) begin
               st_in[i].hrem = 24'(ht - {1'b0, st_ff[i-1].perp});
               st_in[i].hq   = {st_ff[i-1].hq[22:0], 1'b1};
            end else begin
               st_in[i].hrem = ht[23:0];
               st_in[i].hq   = {st_ff[i-1].hq[22:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) begin
            st_ff[i].valid <= 1'b0;
         end
      end else if (adv) begin
         st_ff <= st_in;
      end
   end

   assign txw = (tile == 9'd0) ? st_ff[NS-1].hit : {7'b0, st_ff[NS-1].mrem};

   always_comb begin
      out        = '0;
      out.valid  = st_ff[NS-1].valid;
      out.render = st_ff[NS-1].render;
      out.texnum = st_ff[NS-1].texnum;
      out.off    = st_ff[NS-1].off;
      out.value  = st_ff[NS-1].value;
      out.vert   = st_ff[NS-1].vert;
      out.row    = st_ff[NS-1].row;
      out.hq     = st_ff[NS-1].hovf ? rcs_pkg::HQ_MAX : st_ff[NS-1].hq;
      out.tx     = (txw > 16'(rcs_pkg::TEX_SIZE - 1)) ? TB'(rcs_pkg::TEX_SIZE - 1)
                                                     : txw[TB-1:0];
   end

endmodule

`default_nettype wire

### rtl/core/rcs_texel.sv
`default_nettype none

module rcs_texel (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            adv,
   input  wire rcs_pkg::ht_type hin,
   input  wire logic [10:0]     screen_rows,
   input  wire logic [31:0]     ceiling_color,
   input  wire logic [31:0]     floor_color,
   input  wire logic [8:0]      shade_factor,
   output rcs_pkg::rs_type      res
);

   localparam int TB     = rcs_pkg::TEX_BITS;
   localparam int OFF_W  = rcs_pkg::OFF_W;
   localparam int ADDR_W = rcs_pkg::ADDR_W;
   localparam int NT     = 4 + TB;
   localparam int S_RD   = 2 + TB;
   localparam int S_OUT  = 3 + TB;

   typedef struct packed {
      logic                valid;
      logic                render;
      logic [3:0]          texnum;
      logic [11:0]         off;
      logic [31:0]         value;
      logic                vert;
      logic [9:0]          row;
      logic [TB-1:0]       tx;
      logic [23:0]         hq;
      rcs_pkg::region_type region;
      logic [15:0]         d;
      logic                texok;
      logic                offok;
      logic                hqz;
      logic                tovf;
      logic [23:0]         trem;
      logic [TB-1:0]       tq;
   } tp_type;

   tp_type st_ff [NT];
   tp_type st_in [NT];

   logic [TB-1:0]     ty;
   logic [3:0]        texm1;
   logic [ADDR_W-1:0] raddr;
   logic [ADDR_W-1:0] waddr;
   logic              we;
   logic [31:0]       rdata;
   logic [31:0]       texel;

   function automatic logic [31:0] shade(input logic [31:0] c, input logic [8:0] f);
      logic [16:0] p;
      logic [31:0] r;
      r = c;
      for (int k = 0; k < 3; k++) begin
         p = c[8*k +: 8] * f;
         r[8*k +: 8] = p[16] ? 8'hFF : p[15:8];
      end
      return r;
   endfunction

   always_comb begin
      logic [18:0] half2;
      logic [9:0]  topv;
      logic [24:0] bsum;
      logic [15:0] bq;
      logic [10:0] bottom;
      logic [24:0] num;
      logic [24:0] tt;
      half2  = {screen_rows[10:1], 9'b0};
      topv   = '0;
      bsum   = '0;
      bq     = '0;
      bottom = '0;
      num    = '0;
      tt     = '0;
      st_in[0]        = '0;
      st_in[0].valid  = hin.valid;
      st_in[0].render = hin.render;
      st_in[0].texnum = hin.texnum;
      st_in[0].off    = hin.off;
      st_in[0].value  = hin.value;
      st_in[0].vert   = hin.vert;
      st_in[0].row    = hin.row;
      st_in[0].tx     = hin.tx;
      st_in[0].hq     = hin.hq;
      for (int i = 1; i < NT; i++) begin
         st_in[i] = st_ff[i-1];
         if (i == 1) begin
            if ({5'b0, half2} > st_ff[0].hq) begin
               topv = 10'(({5'b0, half2} - st_ff[0].hq) >> 9);
            end
            bsum   = {6'b0, half2} + {1'b0, st_ff[0].hq};
            bq     = bsum[24:9];
            bottom = (bq > {5'b0, screen_rows}) ? screen_rows : bq[10:0];
            num    = {6'b0, st_ff[0].row, 9'b0} + {1'b0, st_ff[0].hq};
            st_in[1].d = (num > {6'b0, half2}) ? 16'((num - {6'b0, half2}) >> 9) : 16'd0;
            if (st_ff[0].row < topv) begin
               st_in[1].region = rcs_pkg::REGION_CEILING;
            end else if ({1'b0, st_ff[0].row} < bottom) begin
               st_in[1].region = rcs_pkg::REGION_WALL;
            end else begin
               st_in[1].region = rcs_pkg::REGION_FLOOR;
            end
            st_in[1].texok = (st_ff[0].texnum != 4'd0)
                             && ({1'b0, st_ff[0].texnum} <= 5'(rcs_pkg::TEX_COUNT));
            st_in[1].offok = {5'b0, st_ff[0].off} < 17'(rcs_pkg::TEX_TEXELS);
         end
         if (i == 2) begin
            st_in[2].hqz  = st_ff[1].hq == 24'd0;
            st_in[2].tovf = {st_ff[1].d, 8'b0} >= st_ff[1].hq;
            st_in[2].trem = {st_ff[1].d, 8'b0};
            st_in[2].tq   = '0;
         end
         if (i >= 3 && i <= S_RD) begin
            tt = {st_ff[i-1].trem, 1'b0};
            if (tt >= {1'b0, st_ff[i-1].hq}) begin
               st_in[i].trem = 24'(tt - {1'b0, st_ff[i-1].hq});
               st_in[i].tq   = {st_ff[i-1].tq[TB-2:0], 1'b1};
            end else begin
               st_in[i].trem = tt[23:0];
               st_in[i].tq   = {st_ff[i-1].tq[TB-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NT; i++) begin
            st_ff[i].valid <= 1'b0;
         end
      end else if (adv) begin
         st_ff <= st_in;
      end
   end

   assign ty    = st_ff[S_RD].hqz  ? '0 :
                  st_ff[S_RD].tovf ? TB'(rcs_pkg::TEX_SIZE - 1) : st_ff[S_RD].tq;
   assign texm1 = st_ff[S_RD].texnum - 4'd1;
   assign raddr = ADDR_W'({texm1, ty, st_ff[S_RD].tx});
   assign waddr = ADDR_W'({texm1, OFF_W'(st_ff[S_RD].off)});
   assign we    = adv && st_ff[S_RD].valid && !st_ff[S_RD].render
                  && st_ff[S_RD].texok && st_ff[S_RD].offok;

   rcs_ram #(
      .WIDTH(32),
      .DEPTH(rcs_pkg::STORE_DEPTH)
   ) u_store (
      .clock(clock),
      .we   (we),
      .waddr(waddr),
      .wdata(st_ff[S_RD].value),
      .re   (adv),
      .raddr(raddr),
      .rdata(rdata)
   );

   assign texel = st_ff[S_OUT].texok ? rdata : 32'd0;

   always_comb begin
      res        = '0;
      res.valid  = st_ff[S_OUT].valid && st_ff[S_OUT].render;
      res.region = st_ff[S_OUT].region;
      case (st_ff[S_OUT].region)
         rcs_pkg::REGION_CEILING: res.color = ceiling_color;
         rcs_pkg::REGION_WALL:    res.color = st_ff[S_OUT].vert ? shade(texel, shade_factor)
                                                                : texel;
         default:                 res.color = floor_color;
      endcase
   end

endmodule

`default_nettype wire

### rtl/core/raycast_wall_column_shader.sv
// Raycaster wall shader: one pixel per transaction. Load transactions write a texel into the
// 32768 x 32 texture RAM; render transactions give one ray and one screen row and return one
// pixel colour and region. Both kinds share one fully pipelined path, so a new transaction is
// taken every clock while the pipeline is not held, and results leave in order; loads return
// nothing. A request passes through the cosine/height dividers, the texture stage and the
// output register. The rate of one per clock is set by the one-bit-per-stage dividers and the
// texture RAM's separate write and read ports. The whole pipeline holds only while a response
// waits and rsp_ready is low. The texture RAM is not cleared: a texel must be loaded before it
// is drawn. The user must write configuration only while idle; the block does not enforce it.
`default_nettype none

module raycast_wall_column_shader (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_type,
   input  wire logic [3:0]         req_wall_texture,
   input  wire logic [11:0]        req_texel_offset,
   input  wire logic [31:0]        req_texel_value,
   input  wire logic [23:0]        req_ray_distance,
   input  wire logic signed [15:0] req_angle_difference,
   input  wire logic [15:0]        req_hit_x,
   input  wire logic [15:0]        req_hit_y,
   input  wire logic               req_hit_vertical,
   input  wire logic [9:0]         req_screen_row,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [31:0]             rsp_pixel_color,
   output logic [1:0]              rsp_region,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_wdata
);

   logic [10:0] screen_rows_ff, screen_rows_in;
   logic [8:0]  tile_size_ff, tile_size_in;
   logic [11:0] proj_dist_ff, proj_dist_in;
   logic [31:0] ceiling_ff, ceiling_in;
   logic [31:0] floor_ff, floor_in;
   logic [8:0]  shade_ff, shade_in;
   logic [20:0] tile_proj_ff, tile_proj_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         rsp_color_ff, rsp_color_in;
   rcs_pkg::region_type rsp_region_ff, rsp_region_in;

   logic            adv;
   rcs_pkg::rq_type req;
   rcs_pkg::ht_type ht;
   rcs_pkg::rs_type res;

   always_comb begin
      screen_rows_in = screen_rows_ff;
      tile_size_in   = tile_size_ff;
      proj_dist_in   = proj_dist_ff;
      ceiling_in     = ceiling_ff;
      floor_in       = floor_ff;
      shade_in       = shade_ff;
      if (csr_we) begin
         unique case (rcs_pkg::csr_index_type'(csr_index))
            rcs_pkg::CSR_SCREEN_ROWS:   screen_rows_in = csr_wdata[10:0];
            rcs_pkg::CSR_TILE_SIZE:     tile_size_in   = csr_wdata[8:0];
            rcs_pkg::CSR_PROJ_DIST:     proj_dist_in   = csr_wdata[11:0];
            rcs_pkg::CSR_CEILING_COLOR: ceiling_in     = csr_wdata;
            rcs_pkg::CSR_FLOOR_COLOR:   floor_in       = csr_wdata;
            rcs_pkg::CSR_SHADE_FACTOR:  shade_in       = csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   assign tile_proj_in = {12'b0, tile_size_ff} * {9'b0, proj_dist_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_rows_ff <= rcs_pkg::SCREEN_ROWS_RST;
         tile_size_ff   <= rcs_pkg::TILE_SIZE_RST;
         proj_dist_ff   <= rcs_pkg::PROJ_DIST_RST;
         ceiling_ff     <= rcs_pkg::CEILING_RST;
         floor_ff       <= rcs_pkg::FLOOR_RST;
         shade_ff       <= rcs_pkg::SHADE_RST;
      end else begin
         screen_rows_ff <= screen_rows_in;
         tile_size_ff   <= tile_size_in;
         proj_dist_ff   <= proj_dist_in;
         ceiling_ff     <= ceiling_in;
         floor_ff       <= floor_in;
         shade_ff       <= shade_in;
      end
      tile_proj_ff <= tile_proj_in;
   end

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   always_comb begin
      req         = '0;
      req.render  = req_type;
      req.texnum  = req_wall_texture;
      req.off     = req_texel_offset;
      req.value   = req_texel_value;
      req.ray_len = req_ray_distance;
      req.ang     = req_angle_difference;
      req.hit_x   = req_hit_x;
      req.hit_y   = req_hit_y;
      req.vert    = req_hit_vertical;
      req.row     = req_screen_row;
   end

   rcs_height u_height (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid),
      .in_req   (req),
      .tile     (tile_size_ff),
      .tile_proj(tile_proj_ff),
      .out      (ht)
   );

   rcs_texel u_texel (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .hin          (ht),
      .screen_rows  (screen_rows_ff),
      .ceiling_color(ceiling_ff),
      .floor_color  (floor_ff),
      .shade_factor (shade_ff),
      .res          (res)
   );

   assign rsp_valid_in  = adv ? res.valid : rsp_valid_ff;
   assign rsp_color_in  = adv ? res.color : rsp_color_ff;
   assign rsp_region_in = adv ? res.region : rsp_region_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_color_ff  <= rsp_color_in;
      rsp_region_ff <= rsp_region_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_region      = rsp_region_ff;

endmodule

`default_nettype wire

### rtl/core/rcs_checker.sv
`default_nettype none

module rcs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_pixel_color,
   input wire logic [1:0]  rsp_region
);

   // held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_color) && $stable(rsp_region))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

   // request side only stops for a stalled response
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without a held response");

   a_load_on_advance: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_ready))
      else $error("response loaded while pipeline held");

endmodule

bind raycast_wall_column_shader rcs_checker u_checker (.*);

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

   typedef struct {
      bit        render;
      bit [3:0]  tex;
      bit [11:0] off;
      bit [31:0] value;
      bit [23:0] ray_len;
      bit [15:0] ang;
      bit [15:0] hx;
      bit [15:0] hy;
      bit        vert;
      bit [9:0]  row;
      bit        typed;
      bit [31:0] t_color;
      bit [1:0]  t_region;
   } shader_req_type;

   typedef struct {
      bit [31:0] color;
      bit [1:0]  region;
   } pixel_type;

   typedef struct {
      bit [10:0] wh;
      bit [8:0]  tile;
      bit [11:0] proj;
      bit [31:0] ceil_c;
      bit [31:0] floor_c;
      bit [8:0]  shade;
   } view_cfg_type;

   logic clock;
   logic reset;
   logic req_valid, req_ready, req_type, req_hit_vertical;
   logic [3:0] req_wall_texture;
   logic [11:0] req_texel_offset;
   logic [31:0] req_texel_value;
   logic [23:0] req_ray_distance;
   logic signed [15:0] req_angle_difference;
   logic [15:0] req_hit_x, req_hit_y;
   logic [9:0] req_screen_row;
   logic rsp_valid, rsp_ready;
   logic [31:0] rsp_pixel_color;
   logic [1:0] rsp_region;
   logic csr_we;
   logic [2:0] csr_index;
   logic [31:0] csr_wdata;

   raycast_wall_column_shader uut (.*);

   bit [31:0]    texels [rcs_pkg::STORE_DEPTH];
   bit           texel_loaded [rcs_pkg::STORE_DEPTH];
   view_cfg_type view;
   pixel_type    pending_pixels[$];
   int           fail_count;
   int           sender_idle, receiver_idle;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic report(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      fail_count++;
   endtask

   // texel address returned in addr; reads set when a stored texel is used
   function automatic pixel_type shade_pixel(input shader_req_type r, output int addr,
                                             output bit reads);
      longint unsigned a, u, c, perp, hq, half2, top, bottom, hit, tx, num, d, ty;
      bit [31:0] texel, col;
      pixel_type p;
      bit tex_ok;
      reads = 0;
      addr = 0;
      tex_ok = r.tex >= 1 && r.tex <= rcs_pkg::TEX_COUNT;
      a = r.ang;
      u = a[15] ? 65536 - a : a;
      c = (u >= 16384) ? 0 : ((((64'd1 << 30) - 4 * u * u) << 16) / ((64'd1 << 30) + u * u));
      perp = (longint'(r.ray_len) * c) >> 16;
      if (perp == 0) hq = rcs_pkg::HQ_MAX;
      else begin
         hq = ((longint'(view.tile) * view.proj) << 16) / perp;
         if (hq > rcs_pkg::HQ_MAX) hq = rcs_pkg::HQ_MAX;
      end
      half2 = longint'(view.wh >> 1) * 512;
      top = half2 > hq ? (half2 - hq) >> 9 : 0;
      bottom = (half2 + hq) >> 9;
      if (bottom > view.wh) bottom = view.wh;
      if (r.row < top) begin
         p.color = view.ceil_c;
         p.region = rcs_pkg::REGION_CEILING;
      end else if (r.row < bottom) begin
         hit = r.vert ? r.hy : r.hx;
         tx = view.tile != 0 ? hit % view.tile : hit;
         if (tx > rcs_pkg::TEX_SIZE - 1) tx = rcs_pkg::TEX_SIZE - 1;
         num = longint'(r.row) * 512 + hq;
         d = num > half2 ? (num - half2) >> 9 : 0;
         ty = hq != 0 ? (d * rcs_pkg::TEX_SIZE * 256) / hq : 0;
         if (ty > rcs_pkg::TEX_SIZE - 1) ty = rcs_pkg::TEX_SIZE - 1;
         texel = 0;
         if (tex_ok) begin
            addr = int'((r.tex - 1) * rcs_pkg::TEX_TEXELS + ty * rcs_pkg::TEX_SIZE + tx);
            reads = 1;
            texel = texels[addr];
         end
         col = texel;
         if (r.vert)
            for (int k = 0; k < 3; k++) begin
               longint unsigned s;
               s = (longint'(texel[k*8 +: 8]) * view.shade) >> 8;
               col[k*8 +: 8] = s > 255 ? 8'hFF : s[7:0];
            end
         p.color = col;
         p.region = rcs_pkg::REGION_WALL;
      end else begin
         p.color = view.floor_c;
         p.region = rcs_pkg::REGION_FLOOR;
      end
      return p;
   endfunction

   task automatic drive(input shader_req_type r);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_type <= r.render;
      req_wall_texture <= r.tex;
      req_texel_offset <= r.off;
      req_texel_value <= r.value;
      req_ray_distance <= r.ray_len;
      req_angle_difference <= r.ang;
      req_hit_x <= r.hx;
      req_hit_y <= r.hy;
      req_hit_vertical <= r.vert;
      req_screen_row <= r.row;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic issue(input shader_req_type r);
      pixel_type p;
      int addr;
      bit reads;
      shader_req_type ld;
      if (!r.render) begin
         if (r.tex >= 1 && r.tex <= rcs_pkg::TEX_COUNT && r.off < rcs_pkg::TEX_TEXELS) begin
            texels[(r.tex - 1) * rcs_pkg::TEX_TEXELS + r.off] = r.value;
            texel_loaded[(r.tex - 1) * rcs_pkg::TEX_TEXELS + r.off] = 1;
         end
         drive(r);
         return;
      end
      p = shade_pixel(r, addr, reads);
      if (reads && !texel_loaded[addr]) begin
         ld = r;
         ld.render = 0;
         ld.off = 12'(addr % rcs_pkg::TEX_TEXELS);
         ld.value = $urandom;
         issue(ld);
         p = shade_pixel(r, addr, reads);
      end
      if (r.typed) begin
         p.color = r.t_color;
         p.region = r.t_region;
      end
      pending_pixels.push_back(p);
      drive(r);
   endtask

   function automatic shader_req_type random_req();
      shader_req_type r;
      r = '{default: 0};
      r.render = $urandom_range(99) < 70;
      r.tex = $urandom_range(9) == 0 ? 4'($urandom)
                                     : 4'($urandom_range(1, rcs_pkg::TEX_COUNT));
      r.off = 12'($urandom);
      r.value = $urandom;
      case ($urandom_range(3))
         0: r.ray_len = 24'($urandom_range(0, 255));
         1: r.ray_len = 24'($urandom_range(256, 65535));
         2: r.ray_len = 24'($urandom_range(65536, 1 << 20));
         default: r.ray_len = 24'($urandom);
      endcase
      r.ang = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 8191) - 4096);
      r.hx = 16'($urandom);
      r.hy = 16'($urandom);
      r.vert = 1'($urandom);
      r.row = $urandom_range(1) ? 10'($urandom)
                                : 10'($urandom_range(0, view.wh > 0 ? view.wh : 1));
      return r;
   endfunction

   task automatic write_csr(input rcs_pkg::csr_index_type idx, input bit [31:0] data);
      @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 0;
   endtask

   task automatic apply_view(input view_cfg_type v);
      write_csr(rcs_pkg::CSR_SCREEN_ROWS, {21'b0, v.wh});
      write_csr(rcs_pkg::CSR_TILE_SIZE, {23'b0, v.tile});
      write_csr(rcs_pkg::CSR_PROJ_DIST, {20'b0, v.proj});
      write_csr(rcs_pkg::CSR_CEILING_COLOR, v.ceil_c);
      write_csr(rcs_pkg::CSR_FLOOR_COLOR, v.floor_c);
      write_csr(rcs_pkg::CSR_SHADE_FACTOR, {23'b0, v.shade});
      view = v;
   endtask

   always @(negedge clock)
      rsp_ready <= $urandom_range(99) >= receiver_idle;

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0)
            report("pixel with no transaction outstanding");
         else begin
            pixel_type p;
            p = pending_pixels.pop_front();
            if (rsp_pixel_color !== p.color)
               report($sformatf("colour %h, predicted %h", rsp_pixel_color, p.color));
            if (rsp_region !== p.region)
               report($sformatf("region %0d, predicted %0d", rsp_region, p.region));
         end
      end

   shader_req_type directed [$];

   function automatic shader_req_type mk(input bit render, input bit [3:0] tex,
      input bit [11:0] off, input bit [23:0] ray_len, input bit [15:0] ang,
      input bit [15:0] hx, input bit [15:0] hy, input bit vert, input bit [9:0] row,
      input bit typed = 0, input bit [31:0] col = 0, input bit [1:0] reg_v = 0);
      shader_req_type r;
      r = '{render, tex, off, 32'hFFFF_FFFF, ray_len, ang, hx, hy, vert, row, typed, col,
            reg_v};
      return r;
   endfunction

   initial begin
      view_cfg_type phases [6];
      fail_count = 0;
      sender_idle = 36;
      receiver_idle = 56;
      reset = 1;
      req_valid = 0; req_type = 0; req_wall_texture = 0; req_texel_offset = 0;
      req_texel_value = 0; req_ray_distance = 0; req_angle_difference = 0;
      req_hit_x = 0; req_hit_y = 0; req_hit_vertical = 0; req_screen_row = 0;
      rsp_ready = 0; csr_we = 0; csr_index = 0; csr_wdata = 0;
      view = '{rcs_pkg::SCREEN_ROWS_RST, rcs_pkg::TILE_SIZE_RST, rcs_pkg::PROJ_DIST_RST,
               rcs_pkg::CEILING_RST, rcs_pkg::FLOOR_RST, rcs_pkg::SHADE_RST};
      phases[0] = view;
      phases[1] = '{11'd1024, 9'd256, 12'd4095, $urandom, $urandom, 9'd256};
      phases[2] = '{11'd1, 9'd1, 12'd1, 32'h0, 32'hFFFF_FFFF, 9'd0};
      phases[3] = '{11'd480, 9'd0, 12'd300, $urandom, $urandom, 9'd128};
      phases[4] = '{11'($urandom_range(1, 1024)), 9'($urandom_range(1, 256)),
                    12'($urandom_range(1, 4095)), $urandom, $urandom, 9'($urandom_range(256))};
      phases[5] = '{11'd600, 9'd64, 12'd692, $urandom, $urandom, 9'd179};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // far wall: ceiling above, floor below; zero distance and quarter turn fill column
      directed.push_back(mk(1, 1, 0, 24'hFF_FFFF, 0, 0, 0, 0, 0, 1,
                            rcs_pkg::CEILING_RST, rcs_pkg::REGION_CEILING));
      directed.push_back(mk(1, 1, 0, 24'hFF_FFFF, 0, 0, 0, 0, 1023, 1,
                            rcs_pkg::FLOOR_RST, rcs_pkg::REGION_FLOOR));
      directed.push_back(mk(1, 0, 0, 0, 0, 0, 0, 1, 0, 1, 0, rcs_pkg::REGION_WALL));
      directed.push_back(mk(1, 15, 0, 100, 16'h4000, 0, 0, 0, 599, 1, 0,
                            rcs_pkg::REGION_WALL));
      directed.push_back(mk(1, 9, 0, 100, 16'h8000, 0, 0, 1, 300, 1, 0,
                            rcs_pkg::REGION_WALL));
      directed.push_back(mk(1, 1, 0, 24'hFF_FFFF, 0, 0, 0, 0, 600, 1,
                            rcs_pkg::FLOOR_RST, rcs_pkg::REGION_FLOOR));
      directed.push_back(mk(0, 0, 12'd5, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk(0, 9, 12'd5, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk(0, 1, 12'd0, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk(0, 8, 12'hFFF, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk(1, 1, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk(1, 8, 0, 0, 0, 16'hFFFF, 16'hFFFF, 1, 599));
      directed.push_back(mk(1, 8, 0, 24'h00_1000, 16'h3FFF, 63, 65535, 0, 310));
      directed.push_back(mk(1, 4, 0, 24'h00_4000, 16'hC001, 100, 200, 1, 290));
      directed.push_back(mk(1, 2, 0, 24'h00_0800, 16'h7FFF, 0, 0, 1, 1023));

      for (int ph = 0; ph < 6; ph++) begin
         sender_idle = ph < 2 ? 36 : ph < 4 ? 56 : 0;
         receiver_idle = ph < 2 ? 56 : ph < 4 ? 36 : 0;
         if (ph > 0) begin
            @(negedge clock);
            req_valid <= 0;
            wait (pending_pixels.size() == 0);
            repeat (70) @(posedge clock);
            apply_view(phases[ph]);
         end else
            foreach (directed[i]) issue(directed[i]);
         repeat (125) issue(random_req());
      end
      @(negedge clock);
      req_valid <= 0;
      wait (pending_pixels.size() == 0);
      repeat (70) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule

### raycast_wall_column_shader.f
rtl/core/rcs_pkg.sv
rtl/core/rcs_ram.sv
rtl/core/rcs_height.sv
rtl/core/rcs_texel.sv
rtl/core/raycast_wall_column_shader.sv
rtl/core/rcs_checker.sv
bench/testbench.sv
